/* src/bdjc_pkg.sv */
// ----------------------------------------------------------------------------
// bdjc_pkg
// Shared constants, types and arithmetic helpers for the button debounce and
// joystick conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package bdjc_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int ADC_BITS    = 12;
    localparam int ADC_MAX     = (1 << ADC_BITS) - 1;
    localparam int ADC_MID     = ADC_MAX >> 1;
    localparam int PCT_FULL    = 100;
    localparam int PCT_W       = 7;
    localparam int CNT_W       = 16;
    localparam int MENU_W      = 4;
    localparam int NUM_CHAN    = 6;
    localparam int NUM_JOY     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int BIT_BUTTON1 = 5;
    localparam int BIT_BUTTON3 = 3;
    localparam int BIT_BUTTON4 = 2;

    localparam int CHAN_POT_A  = 4;
    localparam int CHAN_POT_B  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_HOLD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_MENU          = 2'd2;

    localparam logic [CNT_W-1:0]  RST_DEBOUNCE_THRESHOLD = 16'd20;
    localparam logic [CNT_W-1:0]  RST_CALIB_HOLD_TICKS   = 16'd5000;
    localparam logic [MENU_W-1:0] RST_LAST_MENU          = 4'd3;

    typedef logic [ADC_BITS-1:0]    t_adc;
    typedef logic signed [ADC_BITS:0] t_offset;
    typedef logic [PCT_W-1:0]       t_pct;
    typedef logic [NUM_BUTTONS-1:0] t_buttons;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [MENU_W-1:0]      t_menu;

    typedef struct packed {
        t_count debounce_threshold;
        t_count calib_hold_ticks;
        t_menu  last_menu;
    } t_cfg;

    typedef struct packed {
        t_buttons stable;
        t_menu    menu;
        logic     capture;
    } t_btn_status;

    typedef struct packed {
        t_buttons              buttons_pressed;
        t_adc [NUM_CHAN-1:0]   raw;
    } t_in_item;

    typedef struct packed {
        t_pct [NUM_CHAN-1:0]   pct;
        t_buttons              buttons_stable;
        t_menu                 menu_index;
    } t_out_item;

    // floor(v * 100 / ADC_MAX) by shift estimate and one correction
    function automatic t_pct scale_pct(input t_adc v);
        logic [ADC_BITS+PCT_W-1:0] p;
        t_pct                      q0;
        logic [ADC_BITS:0]         r;
        p  = (ADC_BITS+PCT_W)'(v) * (ADC_BITS+PCT_W)'(PCT_FULL);
        q0 = p[ADC_BITS+PCT_W-1:ADC_BITS];
        r  = {1'b0, p[ADC_BITS-1:0]} + (ADC_BITS+1)'(q0);
        if (r >= (ADC_BITS+1)'(ADC_MAX)) begin
            scale_pct = q0 + t_pct'(1);
        end else begin
            scale_pct = q0;
        end
    endfunction

    function automatic t_pct joy_pct(input t_adc raw, input t_offset offset);
        logic signed [ADC_BITS+1:0] s;
        t_adc                       v;
        s = $signed({2'b00, raw}) + $signed({offset[ADC_BITS], offset});
        if (s[ADC_BITS+1]) begin
            v = '0;
        end else if (s[ADC_BITS]) begin
            v = t_adc'(ADC_MAX);
        end else begin
            v = s[ADC_BITS-1:0];
        end
        joy_pct = scale_pct(v);
    endfunction

    function automatic t_offset center_offset(input t_adc raw);
        center_offset = $signed((ADC_BITS+1)'(ADC_MID) - {1'b0, raw});
    endfunction

endpackage

`default_nettype wire

/* src/bdjc_in_if.sv */
// ----------------------------------------------------------------------------
// bdjc_in_if
// Input item channel: button levels and six ADC samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdjc_in_if;
    import bdjc_pkg::*;

    logic valid;
    logic ready;
    logic [NUM_BUTTONS-1:0] buttons_pressed;
    logic [ADC_BITS-1:0]    left_vertical_raw;
    logic [ADC_BITS-1:0]    left_horizontal_raw;
    logic [ADC_BITS-1:0]    right_vertical_raw;
    logic [ADC_BITS-1:0]    right_horizontal_raw;
    logic [ADC_BITS-1:0]    pot_a_raw;
    logic [ADC_BITS-1:0]    pot_b_raw;

    modport source (
        output valid, buttons_pressed, left_vertical_raw, left_horizontal_raw,
               right_vertical_raw, right_horizontal_raw, pot_a_raw, pot_b_raw,
        input  ready
    );

    modport sink (
        input  valid, buttons_pressed, left_vertical_raw, left_horizontal_raw,
               right_vertical_raw, right_horizontal_raw, pot_a_raw, pot_b_raw,
        output ready
    );
endinterface

`default_nettype wire

/* src/bdjc_out_if.sv */
// ----------------------------------------------------------------------------
// bdjc_out_if
// Result item channel: percentages, stable buttons and menu index.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdjc_out_if;
    import bdjc_pkg::*;

    logic valid;
    logic ready;
    logic [PCT_W-1:0]       left_vertical_pct;
    logic [PCT_W-1:0]       left_horizontal_pct;
    logic [PCT_W-1:0]       right_vertical_pct;
    logic [PCT_W-1:0]       right_horizontal_pct;
    logic [PCT_W-1:0]       pot_a_pct;
    logic [PCT_W-1:0]       pot_b_pct;
    logic [NUM_BUTTONS-1:0] buttons_stable;
    logic [MENU_W-1:0]      menu_index;

    modport source (
        output valid, left_vertical_pct, left_horizontal_pct, right_vertical_pct,
               right_horizontal_pct, pot_a_pct, pot_b_pct, buttons_stable,
               menu_index,
        input  ready
    );

    modport sink (
        input  valid, left_vertical_pct, left_horizontal_pct, right_vertical_pct,
               right_horizontal_pct, pot_a_pct, pot_b_pct, buttons_stable,
               menu_index,
        output ready
    );
endinterface

`default_nettype wire

/* src/button_debounce_joystick_conditioner_top.sv */
// ----------------------------------------------------------------------------
// button_debounce_joystick_conditioner_top
// Debounces eight buttons, runs the menu index and joystick calibration, and
// turns six ADC samples into percentages.
//
//   channel   dir   handshake          payload
//   i_in      in    valid / ready      buttons_pressed, six raw samples
//   o_out     out   valid / ready      six percentages, buttons_stable, menu
//   cfg       in    i_cfg_we           i_cfg_index, i_cfg_data
//
// one item per cycle sustained while o_out.ready stays high; path from accept to result:
// input register, one pass of debounce and scaling logic, result register
// i_rst_n synchronous: all counters, offsets and menu index clear to zero
// a stalled result holds; one more item waits in the input register
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_joystick_conditioner_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bdjc_in_if.sink                             i_in,
    bdjc_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [bdjc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bdjc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bdjc_pkg::*;

    t_cfg        r_cfg;
    t_in_item    r_in;
    logic        r_in_valid;
    t_out_item   r_out;
    logic        r_out_valid;
    logic        w_adv;
    logic        w_in_take;
    t_btn_status w_status;
    t_pct [NUM_CHAN-1:0] w_pct;

    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_threshold <= RST_DEBOUNCE_THRESHOLD;
            r_cfg.calib_hold_ticks   <= RST_CALIB_HOLD_TICKS;
            r_cfg.last_menu          <= RST_LAST_MENU;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_THRESHOLD: r_cfg.debounce_threshold <= i_cfg_data;
                CFG_CALIB_HOLD_TICKS:   r_cfg.calib_hold_ticks   <= i_cfg_data;
                CFG_LAST_MENU:          r_cfg.last_menu          <= i_cfg_data[MENU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.buttons_pressed <= i_in.buttons_pressed;
            r_in.raw[0]          <= i_in.left_vertical_raw;
            r_in.raw[1]          <= i_in.left_horizontal_raw;
            r_in.raw[2]          <= i_in.right_vertical_raw;
            r_in.raw[3]          <= i_in.right_horizontal_raw;
            r_in.raw[CHAN_POT_A] <= i_in.pot_a_raw;
            r_in.raw[CHAN_POT_B] <= i_in.pot_b_raw;
        end
    end

    bdjc_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_pressed (r_in.buttons_pressed),
        .i_cfg     (r_cfg),
        .o_status  (w_status)
    );

    bdjc_condition u_condition (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_capture (w_status.capture),
        .i_raw     (r_in.raw),
        .o_pct     (w_pct)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.pct            <= w_pct;
            r_out.buttons_stable <= w_status.stable;
            r_out.menu_index     <= w_status.menu;
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.left_vertical_pct    = r_out.pct[0];
    assign o_out.left_horizontal_pct  = r_out.pct[1];
    assign o_out.right_vertical_pct   = r_out.pct[2];
    assign o_out.right_horizontal_pct = r_out.pct[3];
    assign o_out.pot_a_pct            = r_out.pct[CHAN_POT_A];
    assign o_out.pot_b_pct            = r_out.pct[CHAN_POT_B];
    assign o_out.buttons_stable       = r_out.buttons_stable;
    assign o_out.menu_index           = r_out.menu_index;

endmodule

`default_nettype wire

/* src/bdjc_debounce.sv */
// ----------------------------------------------------------------------------
// bdjc_debounce
// Per-button debounce counters, calibration hold timer and menu index.
// ----------------------------------------------------------------------------
`default_nettype none

module bdjc_debounce (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire bdjc_pkg::t_buttons    i_pressed,
    input  wire bdjc_pkg::t_cfg        i_cfg,
    output bdjc_pkg::t_btn_status      o_status
);
    import bdjc_pkg::*;

    t_count [NUM_BUTTONS-1:0] r_count;
    t_count [NUM_BUTTONS-1:0] n_count;
    t_buttons                 r_stable;
    t_buttons                 n_stable;
    t_count                   r_hold;
    t_count                   n_hold;
    t_menu                    r_menu;
    t_menu                    n_menu;
    t_count                   w_thr;
    logic [MENU_W:0]          w_menu_inc;
    logic                     w_capture;

    always_comb begin
        w_thr = (i_cfg.debounce_threshold == '0) ? t_count'(1) : i_cfg.debounce_threshold;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (i_pressed[i]) begin
                if (r_count[i] >= w_thr) begin
                    n_count[i] = w_thr;
                end else begin
                    n_count[i] = r_count[i] + t_count'(1);
                end
                n_stable[i] = r_stable[i] || (n_count[i] == w_thr);
            end else begin
                n_count[i]  = '0;
                n_stable[i] = 1'b0;
            end
        end
    end

    // menu advance on rising stable edge of button 4
    always_comb begin
        w_menu_inc = {1'b0, r_menu} + (MENU_W+1)'(1);
        if (n_stable[BIT_BUTTON4] && !r_stable[BIT_BUTTON4]) begin
            if (w_menu_inc > {1'b0, i_cfg.last_menu}) begin
                n_menu = '0;
            end else begin
                n_menu = w_menu_inc[MENU_W-1:0];
            end
        end else begin
            n_menu = r_menu;
        end
    end

    // calibration hold timer, capture on the tick it steps onto the limit
    always_comb begin
        w_capture = 1'b0;
        if (n_stable[BIT_BUTTON1] && n_stable[BIT_BUTTON3]) begin
            if (r_hold != '1) begin
                n_hold    = r_hold + t_count'(1);
                w_capture = (n_hold == i_cfg.calib_hold_ticks);
            end else begin
                n_hold = r_hold;
            end
        end else begin
            n_hold = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_stable <= '0;
            r_hold   <= '0;
            r_menu   <= '0;
        end else if (i_adv) begin
            r_count  <= n_count;
            r_stable <= n_stable;
            r_hold   <= n_hold;
            r_menu   <= n_menu;
        end
    end

    assign o_status.stable  = n_stable;
    assign o_status.menu    = n_menu;
    assign o_status.capture = w_capture;

`ifndef SYNTHESIS
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> (r_stable & ~$past(i_pressed)) == '0)
        else $error("released button left stable");

    a_hold_needs_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold != '0 |-> r_stable[BIT_BUTTON1] && r_stable[BIT_BUTTON3])
        else $error("hold timer running without buttons 1 and 3");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_menu) && $stable(r_hold) && $stable(r_stable))
        else $error("state changed without an item");

    a_menu_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !(n_stable[BIT_BUTTON4] && !r_stable[BIT_BUTTON4]) |=> $stable(r_menu))
        else $error("menu moved without button 4 edge");
`endif

endmodule

`default_nettype wire

/* src/bdjc_condition.sv */
// ----------------------------------------------------------------------------
// bdjc_condition
// Joystick centering offsets, clamping and percent scaling of all channels.
// ----------------------------------------------------------------------------
`default_nettype none

module bdjc_condition (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_adv,
    input  wire logic                                   i_capture,
    input  wire bdjc_pkg::t_adc [bdjc_pkg::NUM_CHAN-1:0] i_raw,
    output bdjc_pkg::t_pct [bdjc_pkg::NUM_CHAN-1:0]      o_pct
);
    import bdjc_pkg::*;

    t_offset [NUM_JOY-1:0] r_offset;
    t_offset [NUM_JOY-1:0] n_offset;

    always_comb begin
        for (int i = 0; i < NUM_JOY; i++) begin
            n_offset[i] = i_capture ? center_offset(i_raw[i]) : r_offset[i];
            o_pct[i]    = joy_pct(i_raw[i], n_offset[i]);
        end
        o_pct[CHAN_POT_A] = t_pct'(PCT_FULL) - scale_pct(i_raw[CHAN_POT_A]);
        o_pct[CHAN_POT_B] = t_pct'(PCT_FULL) - scale_pct(i_raw[CHAN_POT_B]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_adv) begin
            r_offset <= n_offset;
        end
    end

endmodule

`default_nettype wire
